// ===== rtl/dau_pkg.sv =====
// ----------------------------------------------------------------------------
// dau_pkg
// Shared widths, constants, payload types and helper functions of the
// dihedral angle pipeline.
// ----------------------------------------------------------------------------
package dau_pkg;

   localparam int COORD_WIDTH_DEF  = 32;
   localparam int CORDIC_STEPS_DEF = 24;
   localparam int MAX_STEPS        = 32;

   localparam int BOND_LIM  = 21;
   localparam int BW        = BOND_LIM + 1;
   localparam int WIDE_LIM  = 30;
   localparam int FW        = WIDE_LIM + 1;
   localparam int RG_GUARD  = 9;
   localparam int AW        = 2 * BW + 2;
   localparam int SQW       = 2 * BOND_LIM + 2;
   localparam int NW        = SQW + 2 * RG_GUARD;
   localparam int GW        = NW / 2;
   localparam int UW        = AW + RG_GUARD + 1;
   localparam int PW        = 64;
   localparam int XW        = FW + 3;
   localparam int ZW        = 34;
   localparam int ANGLE_W   = 25;

   localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'd1073741824);
   localparam int ANGLE_MAX   = 11796480;
   localparam int DEG_MUL     = 45;
   localparam int ROUND_SHIFT = 13;

   localparam logic [1:0] REG_BOX_X = 2'd0;
   localparam logic [1:0] REG_BOX_Y = 2'd1;
   localparam logic [1:0] REG_BOX_Z = 2'd2;
   localparam logic [1:0] REG_AXES  = 2'd3;

   typedef struct packed {
      logic [2:0][BW-1:0] b1;
      logic [2:0][BW-1:0] m;
      logic [2:0][BW-1:0] b3;
   } bond_type;

   typedef struct packed {
      logic [2:0][AW-1:0] a;
      logic [2:0][AW-1:0] b;
      logic [2:0][BW-1:0] b3;
      logic               degen;
   } cross_type;

   typedef struct packed {
      logic signed [FW-1:0] c;
      logic signed [FW-1:0] s;
      logic                 zero;
      logic                 degen;
   } pair_type;

   typedef struct packed {
      logic zero;
      logic degen;
   } flag_type;

   function automatic logic [63:0] magnitude(logic [63:0] x);
      return x[63] ? -x : x;
   endfunction

   function automatic logic [6:0] msb_pos(logic [63:0] mg);
      logic [6:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (mg[i]) p = 7'(i);
      end
      return p;
   endfunction

   function automatic logic [6:0] fit_shift(logic [63:0] mg, int lim);
      logic [6:0] k;
      k = '0;
      for (int i = 0; i < 64; i++) begin
         if (mg[i] && i >= lim) k = 7'(i + 1 - lim);
      end
      return k;
   endfunction

   function automatic logic [63:0] trunc_shift(logic [63:0] x, logic [6:0] k);
      logic [63:0] mg;
      mg = magnitude(x) >> k;
      return x[63] ? -mg : mg;
   endfunction

   function automatic logic [31:0] atan_turn(int i);
      logic [31:0] r;
      case (i)
         0: r = 32'd536870912;
         1: r = 32'd316933406;
         2: r = 32'd167458907;
         3: r = 32'd85004756;
         4: r = 32'd42667331;
         5: r = 32'd21354465;
         6: r = 32'd10679838;
         7: r = 32'd5340245;
         8: r = 32'd2670163;
         9: r = 32'd1335087;
         10: r = 32'd667544;
         11: r = 32'd333772;
         12: r = 32'd166886;
         13: r = 32'd83443;
         14: r = 32'd41722;
         15: r = 32'd20861;
         16: r = 32'd10430;
         17: r = 32'd5215;
         18: r = 32'd2608;
         19: r = 32'd1304;
         20: r = 32'd652;
         21: r = 32'd326;
         22: r = 32'd163;
         23: r = 32'd81;
         24: r = 32'd41;
         25: r = 32'd20;
         26: r = 32'd10;
         27: r = 32'd5;
         28: r = 32'd3;
         29: r = 32'd1;
         30: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/dihedral_angle_unit.sv =====
// ----------------------------------------------------------------------------
// dihedral_angle_unit
// Signed dihedral angle of four atoms, minimum-image bonds, CORDIC atan2.
//
//   channel  dir  ports                         beat
//   req      in   req_tvalid/tready/tdata       four atoms, twelve coords
//   rsp      out  rsp_tvalid/tready/tdata/tuser angle, degenerate flag
//   csr      in   csr_psel/penable/pwrite/...   box lengths, periodic axes
//
// One beat per cycle sustained while the result is not stalled (isqrt
// pipeline 31 stages, CORDIC one stage per iteration).
// Synchronous reset clears all valid bits and the box and axes registers.
// A stalled result holds the whole pipeline; req_tready follows the stall.
// ----------------------------------------------------------------------------
module dihedral_angle_unit #(
   parameter int COORD_WIDTH  = dau_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STEPS = dau_pkg::CORDIC_STEPS_DEF,
   localparam int TDATA_W = ((12 * COORD_WIDTH + 7) / 8) * 8,
   localparam int CSR_DW  = (COORD_WIDTH - 1 > 32) ? 64 : 32,
   localparam int CSR_AW  = (CSR_DW == 64) ? 5 : 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // first_x, first_y, first_z, second_x .. fourth_z
   input  logic [TDATA_W-1:0] req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // angle_deg
   output logic [31:0]        rsp_tdata,
   // degenerate
   output logic               rsp_tuser,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   localparam int CW = COORD_WIDTH;

   logic [2:0][CW-2:0]    box_ff;
   logic [2:0]            axes_ff;
   logic [1:0]            csr_idx;
   logic                  adv;
   logic                  bond_vld, cross_vld, sq_vld, dot_vld, out_vld;
   dau_pkg::bond_type     bond;
   dau_pkg::cross_type    cross_q, cross_dly;
   logic [dau_pkg::SQW-1:0] rgsq;
   logic [dau_pkg::GW-1:0]  root;
   logic [$bits(dau_pkg::cross_type)-1:0] side_dly;
   dau_pkg::pair_type     pair;
   logic [dau_pkg::ANGLE_W-1:0] angle;
   logic                  degen;

   assign csr_idx    = csr_paddr[CSR_AW-1:CSR_AW-2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff  <= '0;
         axes_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_idx)
            dau_pkg::REG_BOX_X: box_ff[0] <= csr_pwdata[CW-2:0];
            dau_pkg::REG_BOX_Y: box_ff[1] <= csr_pwdata[CW-2:0];
            dau_pkg::REG_BOX_Z: box_ff[2] <= csr_pwdata[CW-2:0];
            dau_pkg::REG_AXES:  axes_ff   <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         dau_pkg::REG_BOX_X: csr_prdata = CSR_DW'(box_ff[0]);
         dau_pkg::REG_BOX_Y: csr_prdata = CSR_DW'(box_ff[1]);
         dau_pkg::REG_BOX_Z: csr_prdata = CSR_DW'(box_ff[2]);
         dau_pkg::REG_AXES:  csr_prdata = CSR_DW'(axes_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign adv        = !out_vld || rsp_tready;
   assign req_tready = adv;

   dau_bond #(.COORD_WIDTH(COORD_WIDTH)) u_bond (
      .clock(clock), .reset(reset), .adv(adv), .in_vld(req_tvalid),
      .coords(req_tdata[12*CW-1:0]), .box_len(box_ff), .periodic(axes_ff),
      .out_vld(bond_vld), .out_bond(bond)
   );

   dau_cross u_cross (
      .clock(clock), .reset(reset), .adv(adv), .in_vld(bond_vld), .in_bond(bond),
      .out_vld(cross_vld), .out_cross(cross_q), .out_rgsq(rgsq)
   );

   dau_isqrt #(.SIDE_W($bits(dau_pkg::cross_type))) u_isqrt (
      .clock(clock), .reset(reset), .adv(adv), .in_vld(cross_vld), .in_rgsq(rgsq),
      .in_side(cross_q), .out_vld(sq_vld), .out_root(root), .out_side(side_dly)
   );

   assign cross_dly = dau_pkg::cross_type'(side_dly);

   dau_dot u_dot (
      .clock(clock), .reset(reset), .adv(adv), .in_vld(sq_vld), .in_cross(cross_dly),
      .in_root(root), .out_vld(dot_vld), .out_pair(pair)
   );

   dau_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .adv(adv), .in_vld(dot_vld), .in_pair(pair),
      .out_vld(out_vld), .out_angle(angle), .out_degen(degen)
   );

   assign rsp_tvalid = out_vld;
   assign rsp_tdata  = {(32 - dau_pkg::ANGLE_W)'(0), angle};
   assign rsp_tuser  = degen;

endmodule

// ===== rtl/dau_bond.sv =====
// ----------------------------------------------------------------------------
// dau_bond
// Bond vectors, minimum-image wrap and power-of-two scaling, four stages.
// ----------------------------------------------------------------------------
module dau_bond #(
   parameter int COORD_WIDTH = dau_pkg::COORD_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_vld,
   input  logic [12*COORD_WIDTH-1:0]    coords,
   input  logic [2:0][COORD_WIDTH-2:0]  box_len,
   input  logic [2:0]                   periodic,
   output logic                         out_vld,
   output dau_pkg::bond_type            out_bond
);

   localparam int CW = COORD_WIDTH;
   localparam int DW = CW + 2;
   localparam int BW = dau_pkg::BW;

   logic [2:0][DW-1:0] d1_s1_ff, dm_s1_ff, d3_s1_ff;
   logic [2:0][DW-1:0] d1_s2_ff, dm_s2_ff, d3_s2_ff;
   logic [2:0][DW-1:0] d1_s3_ff, dm_s3_ff, d3_s3_ff;
   logic [2:0][BW-1:0] b1_in, m_in, b3_in;
   logic               vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   dau_pkg::bond_type  bond_ff;

   function automatic logic [DW-1:0] coord(int atom, int ax);
      return DW'($signed(coords[(3*atom+ax)*CW +: CW]));
   endfunction

   function automatic logic [DW-1:0] wrap_c(logic [DW-1:0] d, logic [CW-2:0] l, logic en);
      logic          neg;
      logic [DW-1:0] mg;
      logic [DW:0]   twice;
      logic [DW-1:0] lx;
      neg   = d[DW-1];
      mg    = neg ? -d : d;
      twice = {mg, 1'b0};
      lx    = DW'(l);
      if (en && twice > (DW+1)'(l)) return neg ? d + lx : d - lx;
      return d;
   endfunction

   function automatic logic [2:0][BW-1:0] fit_vec(logic [2:0][DW-1:0] d);
      logic [63:0]        mor;
      logic [6:0]         k;
      logic [2:0][BW-1:0] r;
      mor = '0;
      for (int j = 0; j < 3; j++) mor = mor | dau_pkg::magnitude(64'($signed(d[j])));
      k = dau_pkg::fit_shift(mor, dau_pkg::BOND_LIM);
      for (int j = 0; j < 3; j++) r[j] = BW'(dau_pkg::trunc_shift(64'($signed(d[j])), k));
      return r;
   endfunction

   always_comb begin
      b1_in = fit_vec(d1_s3_ff);
      m_in  = fit_vec(dm_s3_ff);
      b3_in = fit_vec(d3_s3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            d1_s1_ff[j] <= coord(0, j) - coord(1, j);
            dm_s1_ff[j] <= coord(2, j) - coord(1, j);
            d3_s1_ff[j] <= coord(3, j) - coord(2, j);
            d1_s2_ff[j] <= wrap_c(d1_s1_ff[j], box_len[j], periodic[j]);
            dm_s2_ff[j] <= wrap_c(dm_s1_ff[j], box_len[j], periodic[j]);
            d3_s2_ff[j] <= wrap_c(d3_s1_ff[j], box_len[j], periodic[j]);
            d1_s3_ff[j] <= d1_s2_ff[j];
            dm_s3_ff[j] <= wrap_c(-dm_s2_ff[j], box_len[j], periodic[j]);
            d3_s3_ff[j] <= d3_s2_ff[j];
         end
         bond_ff.b1 <= b1_in;
         bond_ff.m  <= m_in;
         bond_ff.b3 <= b3_in;
      end
   end

   assign out_vld  = vld4_ff;
   assign out_bond = bond_ff;

endmodule

// ===== rtl/dau_cross.sv =====
// ----------------------------------------------------------------------------
// dau_cross
// Cross products a = b1 x m, b = b3 x m and |m|^2, two stages.
// ----------------------------------------------------------------------------
module dau_cross (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_vld,
   input  dau_pkg::bond_type  in_bond,
   output logic               out_vld,
   output dau_pkg::cross_type out_cross,
   output logic [dau_pkg::SQW-1:0] out_rgsq
);

   localparam int BW  = dau_pkg::BW;
   localparam int AW  = dau_pkg::AW;
   localparam int SQW = dau_pkg::SQW;
   localparam int PRW = 2 * BW;

   logic signed [BW-1:0]  b1s [3];
   logic signed [BW-1:0]  ms  [3];
   logic signed [BW-1:0]  b3s [3];
   logic signed [PRW-1:0] pa_ff [6];
   logic signed [PRW-1:0] pb_ff [6];
   logic signed [PRW-1:0] sq_ff [3];
   logic [2:0][BW-1:0]    b3_ff;
   logic                  vld1_ff, vld2_ff;
   logic [2:0][AW-1:0]    a_in, b_in;
   dau_pkg::cross_type    cross_ff;
   logic [SQW-1:0]        rgsq_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         b1s[j] = $signed(in_bond.b1[j]);
         ms[j]  = $signed(in_bond.m[j]);
         b3s[j] = $signed(in_bond.b3[j]);
      end
      for (int j = 0; j < 3; j++) begin
         a_in[j] = AW'(pa_ff[2*j]) - AW'(pa_ff[2*j+1]);
         b_in[j] = AW'(pb_ff[2*j]) - AW'(pb_ff[2*j+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
      end
      if (adv) begin
         pa_ff[0] <= b1s[1] * ms[2];
         pa_ff[1] <= b1s[2] * ms[1];
         pa_ff[2] <= b1s[2] * ms[0];
         pa_ff[3] <= b1s[0] * ms[2];
         pa_ff[4] <= b1s[0] * ms[1];
         pa_ff[5] <= b1s[1] * ms[0];
         pb_ff[0] <= b3s[1] * ms[2];
         pb_ff[1] <= b3s[2] * ms[1];
         pb_ff[2] <= b3s[2] * ms[0];
         pb_ff[3] <= b3s[0] * ms[2];
         pb_ff[4] <= b3s[0] * ms[1];
         pb_ff[5] <= b3s[1] * ms[0];
         for (int j = 0; j < 3; j++) sq_ff[j] <= ms[j] * ms[j];
         b3_ff <= in_bond.b3;
         cross_ff.a     <= a_in;
         cross_ff.b     <= b_in;
         cross_ff.b3    <= b3_ff;
         cross_ff.degen <= (a_in == '0) || (b_in == '0);
         rgsq_ff <= SQW'(sq_ff[0]) + SQW'(sq_ff[1]) + SQW'(sq_ff[2]);
      end
   end

   assign out_vld   = vld2_ff;
   assign out_cross = cross_ff;
   assign out_rgsq  = rgsq_ff;

endmodule

// ===== rtl/dau_isqrt.sv =====
// ----------------------------------------------------------------------------
// dau_isqrt
// Pipelined integer square root of |m|^2 * 2^18, one result bit per stage,
// with a side payload carried alongside.
// ----------------------------------------------------------------------------
module dau_isqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_vld,
   input  logic [dau_pkg::SQW-1:0] in_rgsq,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_vld,
   output logic [dau_pkg::GW-1:0]  out_root,
   output logic [SIDE_W-1:0]       out_side
);

   localparam int NW = dau_pkg::NW;
   localparam int NI = dau_pkg::GW;

   logic [NW-1:0]     rem_ff  [NI];
   logic [NW-1:0]     res_ff  [NI];
   logic [SIDE_W-1:0] side_ff [NI];
   logic              vld_ff  [NI];

   for (genvar i = 0; i < NI; i++) begin : g_stage
      localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2*i);
      logic [NW-1:0]     rem_src, res_src, trial;
      logic [SIDE_W-1:0] side_src;
      logic              vld_src;
      if (i == 0) begin : g_first
         assign rem_src  = {in_rgsq, (2*dau_pkg::RG_GUARD)'(0)};
         assign res_src  = '0;
         assign side_src = in_side;
         assign vld_src  = in_vld;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign res_src  = res_ff[i-1];
         assign side_src = side_ff[i-1];
         assign vld_src  = vld_ff[i-1];
      end
      assign trial = res_src + BIT;
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_src;
         end
         if (adv) begin
            if (rem_src >= trial) begin
               rem_ff[i] <= rem_src - trial;
               res_ff[i] <= (res_src >> 1) + BIT;
            end else begin
               rem_ff[i] <= rem_src;
               res_ff[i] <= res_src >> 1;
            end
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_vld  = vld_ff[NI-1];
   assign out_root = res_ff[NI-1][NI-1:0];
   assign out_side = side_ff[NI-1];

endmodule

// ===== rtl/dau_dot.sv =====
// ----------------------------------------------------------------------------
// dau_dot
// Forms u, v, the dot products c = a.u and s = a.v, and normalises the pair,
// five stages.
// ----------------------------------------------------------------------------
module dau_dot (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_vld,
   input  dau_pkg::cross_type     in_cross,
   input  logic [dau_pkg::GW-1:0] in_root,
   output logic                   out_vld,
   output dau_pkg::pair_type      out_pair
);

   localparam int AW = dau_pkg::AW;
   localparam int UW = dau_pkg::UW;
   localparam int FW = dau_pkg::FW;
   localparam int PW = dau_pkg::PW;
   localparam int WL = dau_pkg::WIDE_LIM;

   logic [5:0][UW-1:0]     uv_ff;
   logic [2:0][FW-1:0]     a8_ff, a9_ff;
   logic [5:0][FW-1:0]     uvf_ff;
   logic signed [2*FW-1:0] pr_ff [6];
   logic signed [PW-1:0]   c_ff, s_ff;
   logic [3:0]             dg_ff;
   logic                   zero_ff;
   logic [4:0]             vld_ff;
   logic [2:0][FW-1:0]     af_in;
   logic [5:0][FW-1:0]     uvf_in;
   logic signed [PW-1:0]   c_in, s_in;
   dau_pkg::pair_type      pair_in, pair_ff;

   always_comb begin
      logic [63:0] mor;
      logic [6:0]  k;
      logic [63:0] mc, ms;
      logic [6:0]  p;
      logic [63:0] nc, ns;
      mor = '0;
      for (int j = 0; j < 3; j++) mor = mor | dau_pkg::magnitude(64'($signed(in_cross.a[j])));
      k = dau_pkg::fit_shift(mor, WL);
      for (int j = 0; j < 3; j++)
         af_in[j] = FW'(dau_pkg::trunc_shift(64'($signed(in_cross.a[j])), k));

      mor = '0;
      for (int j = 0; j < 6; j++) mor = mor | dau_pkg::magnitude(64'($signed(uv_ff[j])));
      k = dau_pkg::fit_shift(mor, WL);
      for (int j = 0; j < 6; j++)
         uvf_in[j] = FW'(dau_pkg::trunc_shift(64'($signed(uv_ff[j])), k));

      c_in = PW'(pr_ff[0]) + PW'(pr_ff[1]) + PW'(pr_ff[2]);
      s_in = PW'(pr_ff[3]) + PW'(pr_ff[4]) + PW'(pr_ff[5]);

      mc = dau_pkg::magnitude(c_ff);
      ms = dau_pkg::magnitude(s_ff);
      p  = dau_pkg::msb_pos(mc | ms);
      if (p > 7'(WL - 1)) begin
         nc = mc >> (p - 7'(WL - 1));
         ns = ms >> (p - 7'(WL - 1));
      end else begin
         nc = mc << (7'(WL - 1) - p);
         ns = ms << (7'(WL - 1) - p);
      end
      pair_in.c     = c_ff[PW-1] ? -FW'(nc) : FW'(nc);
      pair_in.s     = s_ff[PW-1] ? -FW'(ns) : FW'(ns);
      pair_in.zero  = zero_ff;
      pair_in.degen = dg_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[3:0], in_vld};
      end
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            uv_ff[j]     <= UW'($signed(in_cross.b[j])) <<< dau_pkg::RG_GUARD;
            uv_ff[3 + j] <= UW'($signed({1'b0, in_root}) * $signed(in_cross.b3[j]));
         end
         a8_ff  <= af_in;
         a9_ff  <= a8_ff;
         uvf_ff <= uvf_in;
         for (int j = 0; j < 3; j++) begin
            pr_ff[j]     <= $signed(a9_ff[j]) * $signed(uvf_ff[j]);
            pr_ff[3 + j] <= $signed(a9_ff[j]) * $signed(uvf_ff[3 + j]);
         end
         c_ff    <= c_in;
         s_ff    <= s_in;
         zero_ff <= (c_in == '0) && (s_in == '0);
         dg_ff   <= {dg_ff[2:0], in_cross.degen};
         pair_ff <= pair_in;
      end
   end

   assign out_vld  = vld_ff[4];
   assign out_pair = pair_ff;

endmodule

// ===== rtl/dau_cordic.sv =====
// ----------------------------------------------------------------------------
// dau_cordic
// Vectoring CORDIC with quarter-turn pre-rotation, one iteration per stage,
// then scaling to 1/65536 degree. The last register is the result beat.
// ----------------------------------------------------------------------------
module dau_cordic #(
   parameter int CORDIC_STEPS = dau_pkg::CORDIC_STEPS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_vld,
   input  dau_pkg::pair_type           in_pair,
   output logic                        out_vld,
   output logic [dau_pkg::ANGLE_W-1:0] out_angle,
   output logic                        out_degen
);

   localparam int NS = (CORDIC_STEPS > dau_pkg::MAX_STEPS) ? dau_pkg::MAX_STEPS : CORDIC_STEPS;
   localparam int XW = dau_pkg::XW;
   localparam int ZW = dau_pkg::ZW;
   localparam int MW = ZW + 6;
   localparam int OW = dau_pkg::ANGLE_W;

   logic signed [XW-1:0] px_ff, py_ff;
   logic signed [ZW-1:0] pz_ff;
   logic                 pv_ff;
   dau_pkg::flag_type    pf_ff;
   logic signed [XW-1:0] x_ff [NS];
   logic signed [XW-1:0] y_ff [NS];
   logic signed [ZW-1:0] z_ff [NS];
   logic                 v_ff [NS];
   dau_pkg::flag_type    f_ff [NS];
   logic [MW-1:0]        prod_ff;
   logic                 zneg_ff, va_ff, vb_ff;
   dau_pkg::flag_type    fa_ff;
   logic [OW-1:0]        angle_ff;
   logic                 degen_ff;
   logic signed [XW-1:0] cx, sx;
   logic [ZW-1:0]        zmag;
   logic [MW-1:0]        r_in;
   logic [OW-1:0]        angle_in;

   assign cx = XW'(in_pair.c);
   assign sx = XW'(in_pair.s);

   for (genvar i = 0; i < NS; i++) begin : g_step
      localparam logic signed [ZW-1:0] ATAN = ZW'(dau_pkg::atan_turn(i));
      logic signed [XW-1:0] xs, ys;
      logic signed [ZW-1:0] zs;
      logic                 vs;
      dau_pkg::flag_type    fs;
      if (i == 0) begin : g_first
         assign xs = px_ff;
         assign ys = py_ff;
         assign zs = pz_ff;
         assign vs = pv_ff;
         assign fs = pf_ff;
      end else begin : g_next
         assign xs = x_ff[i-1];
         assign ys = y_ff[i-1];
         assign zs = z_ff[i-1];
         assign vs = v_ff[i-1];
         assign fs = f_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (adv) begin
            v_ff[i] <= vs;
         end
         if (adv) begin
            if (ys >= 0) begin
               x_ff[i] <= xs + (ys >>> i);
               y_ff[i] <= ys - (xs >>> i);
               z_ff[i] <= zs + ATAN;
            end else begin
               x_ff[i] <= xs - (ys >>> i);
               y_ff[i] <= ys + (xs >>> i);
               z_ff[i] <= zs - ATAN;
            end
            f_ff[i] <= fs;
         end
      end
   end

   always_comb begin
      logic [MW-1:0] r;
      zmag = z_ff[NS-1][ZW-1] ? ZW'(-z_ff[NS-1]) : ZW'(z_ff[NS-1]);
      r    = (prod_ff + MW'(1 << (dau_pkg::ROUND_SHIFT - 1))) >> dau_pkg::ROUND_SHIFT;
      if (r > MW'(dau_pkg::ANGLE_MAX)) r = MW'(dau_pkg::ANGLE_MAX);
      r_in = r;
      if (fa_ff.degen || fa_ff.zero) angle_in = '0;
      else if (zneg_ff)              angle_in = -OW'(r_in);
      else                           angle_in = OW'(r_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (adv) begin
         pv_ff <= in_vld;
         va_ff <= v_ff[NS-1];
         vb_ff <= va_ff;
      end
      if (adv) begin
         if (cx < 0) begin
            if (sx >= 0) begin
               px_ff <= sx;
               py_ff <= -cx;
               pz_ff <= dau_pkg::QUARTER_TURN;
            end else begin
               px_ff <= -sx;
               py_ff <= cx;
               pz_ff <= -dau_pkg::QUARTER_TURN;
            end
         end else begin
            px_ff <= cx;
            py_ff <= sx;
            pz_ff <= '0;
         end
         pf_ff.zero  <= in_pair.zero;
         pf_ff.degen <= in_pair.degen;
         prod_ff  <= MW'(zmag) * MW'(dau_pkg::DEG_MUL);
         zneg_ff  <= z_ff[NS-1][ZW-1];
         fa_ff    <= f_ff[NS-1];
         angle_ff <= angle_in;
         degen_ff <= fa_ff.degen;
      end
   end

   assign out_vld   = vb_ff;
   assign out_angle = angle_ff;
   assign out_degen = degen_ff;

endmodule

// ===== rtl/dau_checker.sv =====
// ----------------------------------------------------------------------------
// dau_checker
// Port-level checks on the dihedral angle unit, bound to the top level.
// ----------------------------------------------------------------------------
module dau_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [31:0]        rsp_tdata,
   input logic               rsp_tuser
);

   logic signed [dau_pkg::ANGLE_W-1:0] angle;
   assign angle = $signed(rsp_tdata[dau_pkg::ANGLE_W-1:0]);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> angle == 0)
      else $error("degenerate beat with nonzero angle");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (angle <= dau_pkg::ANGLE_MAX) && (angle >= -dau_pkg::ANGLE_MAX))
      else $error("angle out of range");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted while result stalled");

endmodule

bind dihedral_angle_unit dau_checker u_dau_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);

// ===== tb/sv/dihedral_checker.sv =====
// ----------------------------------------------------------------------------
// dihedral_checker
// Watches the request and result streams of the dihedral angle unit and the
// register writes, predicts each angle from the atom positions and compares.
// ----------------------------------------------------------------------------
module dihedral_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [383:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [31:0]  rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic         csr_pready,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output int           fail_count,
   output int           pending
);

   typedef struct {
      logic [24:0] angle;
      logic        degen;
   } angle_type;

   angle_type   angle_q[$];
   longint      box_len[3];
   logic [2:0]  axes;

   function automatic longint mag_of(longint x);
      return x < 0 ? -x : x;
   endfunction

   function automatic longint trunc_sh(longint x, int k);
      longint m;
      m = mag_of(x) >>> k;
      return x < 0 ? -m : m;
   endfunction

   function automatic longint floor_sh(longint x, int k);
      return x >>> k;
   endfunction

   function automatic void scale_down(ref longint v[6], input int n, input int lim);
      longint m;
      int k;
      m = 0;
      k = 0;
      for (int i = 0; i < n; i++) if (mag_of(v[i]) > m) m = mag_of(v[i]);
      while (k < 63 && (m >>> k) >= (64'sd1 <<< lim)) k++;
      for (int i = 0; i < n; i++) v[i] = trunc_sh(v[i], k);
   endfunction

   function automatic void min_image(ref longint d[6]);
      for (int i = 0; i < 3; i++) begin
         if (axes[i] && 2 * mag_of(d[i]) > box_len[i])
            d[i] = d[i] < 0 ? d[i] + box_len[i] : d[i] - box_len[i];
      end
   endfunction

   function automatic longint root_floor(longint n);
      longint res, bit_w;
      res = 0;
      bit_w = 64'sd1 <<< 62;
      while (bit_w > n) bit_w = bit_w >>> 2;
      while (bit_w != 0) begin
         if (n >= res + bit_w) begin
            n = n - (res + bit_w);
            res = (res >>> 1) + bit_w;
         end else begin
            res = res >>> 1;
         end
         bit_w = bit_w >>> 2;
      end
      return res;
   endfunction

   function automatic angle_type dihedral_of(logic [383:0] d);
      longint atan_tab[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
         21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
         83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
         10, 5, 3, 1, 1, 0};
      longint p[12];
      longint b1[6], mv[6], b3[6], av[6], bv[6], uv[6], pr[6];
      longint x, y, z, t, dx, dy, g, r;
      angle_type res;
      for (int j = 0; j < 12; j++) p[j] = longint'($signed(d[32*j +: 32]));
      for (int j = 0; j < 6; j++) begin
         b1[j] = 0; mv[j] = 0; b3[j] = 0; av[j] = 0; bv[j] = 0; pr[j] = 0;
      end
      for (int j = 0; j < 3; j++) begin
         b1[j] = p[j] - p[3+j];
         mv[j] = p[6+j] - p[3+j];
         b3[j] = p[9+j] - p[6+j];
      end
      min_image(b1);
      min_image(mv);
      for (int j = 0; j < 3; j++) mv[j] = -mv[j];
      min_image(mv);
      min_image(b3);
      scale_down(b1, 3, 21);
      scale_down(mv, 3, 21);
      scale_down(b3, 3, 21);
      av[0] = b1[1]*mv[2] - b1[2]*mv[1];
      av[1] = b1[2]*mv[0] - b1[0]*mv[2];
      av[2] = b1[0]*mv[1] - b1[1]*mv[0];
      bv[0] = b3[1]*mv[2] - b3[2]*mv[1];
      bv[1] = b3[2]*mv[0] - b3[0]*mv[2];
      bv[2] = b3[0]*mv[1] - b3[1]*mv[0];
      res.angle = '0;
      res.degen = 1'b1;
      if ((av[0] == 0 && av[1] == 0 && av[2] == 0) ||
          (bv[0] == 0 && bv[1] == 0 && bv[2] == 0)) return res;
      res.degen = 1'b0;
      g = root_floor((mv[0]*mv[0] + mv[1]*mv[1] + mv[2]*mv[2]) <<< 18);
      for (int j = 0; j < 3; j++) begin
         uv[j] = bv[j] <<< 9;
         uv[3+j] = g * b3[j];
      end
      scale_down(av, 3, 30);
      scale_down(uv, 6, 30);
      pr[0] = av[0]*uv[0] + av[1]*uv[1] + av[2]*uv[2];
      pr[1] = av[0]*uv[3] + av[1]*uv[4] + av[2]*uv[5];
      if (pr[0] == 0 && pr[1] == 0) return res;
      scale_down(pr, 2, 30);
      while (mag_of(pr[0]) < (64'sd1 <<< 29) && mag_of(pr[1]) < (64'sd1 <<< 29)) begin
         pr[0] = pr[0] * 2;
         pr[1] = pr[1] * 2;
      end
      x = pr[0];
      y = pr[1];
      z = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 1073741824;
         end else begin
            x = -y; y = t; z = -1073741824;
         end
      end
      for (int i = 0; i < dau_pkg::CORDIC_STEPS_DEF && i < 32; i++) begin
         dx = floor_sh(y, i);
         dy = floor_sh(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_tab[i];
         end else begin
            x -= dx; y += dy; z -= atan_tab[i];
         end
      end
      r = (mag_of(z) * 45 + 4096) / 8192;
      if (r > dau_pkg::ANGLE_MAX) r = dau_pkg::ANGLE_MAX;
      if (z < 0) r = -r;
      res.angle = r[24:0];
      return res;
   endfunction

   assign pending = angle_q.size();

   always @(posedge clock) begin
      angle_type exp_a;
      if (reset) begin
         angle_q.delete();
         box_len = '{0, 0, 0};
         axes <= '0;
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               dau_pkg::REG_BOX_X: box_len[0] = longint'(csr_pwdata[30:0]);
               dau_pkg::REG_BOX_Y: box_len[1] = longint'(csr_pwdata[30:0]);
               dau_pkg::REG_BOX_Z: box_len[2] = longint'(csr_pwdata[30:0]);
               dau_pkg::REG_AXES:  axes <= csr_pwdata[2:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) angle_q.push_back(dihedral_of(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (angle_q.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual angle %0d degen %0b",
                        $time, $signed(rsp_tdata[24:0]), rsp_tuser);
               fail_count <= fail_count + 1;
            end else begin
               exp_a = angle_q.pop_front();
               if (rsp_tdata[24:0] !== exp_a.angle || rsp_tuser !== exp_a.degen) begin
                  $display("%0t: expected angle %0d degen %0b, actual angle %0d degen %0b",
                           $time, $signed(exp_a.angle), exp_a.degen,
                           $signed(rsp_tdata[24:0]), rsp_tuser);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives atom quadruples and box settings into the dihedral angle unit under
// varying source gaps and sink stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [383:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           fail_count;
   int           pending;
   int           gap_pct;
   int           stall_pct;
   int           hold_cycles;

   dihedral_angle_unit uut (.*);

   dihedral_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // sink: random stalls, or a long hold-off when requested
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic set_box(input logic [31:0] lx, input logic [31:0] ly,
                          input logic [31:0] lz, input logic [2:0] ax);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      csr_write(dau_pkg::REG_BOX_X, lx);
      csr_write(dau_pkg::REG_BOX_Y, ly);
      csr_write(dau_pkg::REG_BOX_Z, lz);
      csr_write(dau_pkg::REG_AXES, {29'd0, ax});
   endtask

   task automatic send_atoms(input logic [383:0] d);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // plausible molecule: four atoms within +-spread of a random centre on each axis
   function automatic logic [383:0] chain_atoms(input int spread);
      logic [383:0] d;
      logic [31:0] base[3];
      for (int k = 0; k < 3; k++) base[k] = $urandom;
      for (int j = 0; j < 12; j++)
         d[32*j +: 32] = base[j % 3] + 32'($signed($urandom_range(2*spread)) - spread);
      return d;
   endfunction

   function automatic logic [383:0] wild_atoms();
      logic [383:0] d;
      for (int j = 0; j < 12; j++) begin
         case ($urandom_range(3))
            0: d[32*j +: 32] = 32'h8000_0000;
            1: d[32*j +: 32] = 32'h7fff_ffff;
            default: d[32*j +: 32] = $urandom;
         endcase
      end
      return d;
   endfunction

   function automatic logic [383:0] atoms_of(input int c[12]);
      logic [383:0] d;
      for (int j = 0; j < 12; j++) d[32*j +: 32] = 32'(c[j] * 65536);
      return d;
   endfunction

   function automatic logic [383:0] next_item();
      if ($urandom_range(9) < 7)
         return chain_atoms($urandom_range(1) ? 32'd400000 : 32'd40);
      return wild_atoms();
   endfunction

   initial begin
      logic [383:0] d;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      gap_pct = 0; stall_pct = 0; hold_cycles = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: trans, cis, +-90, collinear, coincident, extremes
      send_atoms(atoms_of('{1,0,0, 0,0,0, 0,1,0, -1,1,0}));
      send_atoms(atoms_of('{1,0,0, 0,0,0, 0,1,0, 1,1,0}));
      send_atoms(atoms_of('{1,0,0, 0,0,0, 0,1,0, 0,1,1}));
      send_atoms(atoms_of('{1,0,0, 0,0,0, 0,1,0, 0,1,-1}));
      send_atoms(atoms_of('{0,0,0, 0,1,0, 0,2,0, 1,3,0}));
      send_atoms(atoms_of('{0,0,0, 0,0,0, 0,0,0, 0,0,0}));
      send_atoms(atoms_of('{2,0,0, 0,0,0, 0,1,0, -3,1,1}));
      d = '0;
      for (int j = 0; j < 12; j++) d[32*j +: 32] = (j % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
      send_atoms(d);
      for (int j = 0; j < 12; j++) d[32*j +: 32] = (j % 3) ? 32'h7fff_ffff : 32'h8000_0000;
      send_atoms(d);
      send_atoms({12{32'hffff_ffff}});
      for (int n = 0; n < 6; n++) send_atoms(wild_atoms());

      // periodic box: bonds crossing the boundary, zero length on one axis
      set_box(32'd10 << 16, 32'd12 << 16, 32'd0, 3'b111);
      send_atoms(atoms_of('{9,0,0, 1,0,0, 1,1,0, 10,1,0}));
      send_atoms(atoms_of('{1,0,0, 0,0,0, 0,11,0, 1,11,1}));
      send_atoms(atoms_of('{100,0,0, 0,0,0, 0,1,0, -1,1,3}));
      for (int n = 0; n < 5; n++) send_atoms(chain_atoms(600000));

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 55; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 55; end
            default: begin gap_pct = 27; stall_pct = 27; end
         endcase
         case (ph)
            0: set_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 3'b111);
            1: set_box(32'd0, 32'd0, 32'd0, 3'b000);
            2: set_box($urandom, $urandom, $urandom, 3'b101);
            3: set_box(32'd20 << 16, 32'd30 << 16, 32'd25 << 16, 3'b111);
            4: set_box(32'hffff_ffff, 32'd1, 32'd3 << 16, 3'b010);
            5: set_box(32'd8 << 16, 32'd8 << 16, 32'd8 << 16, 3'b011);
            6: set_box($urandom, $urandom, $urandom, 3'b110);
            default: set_box(32'd5 << 16, 32'd400 << 16, 32'd1 << 16, 3'b100);
         endcase
         if (ph == 0) hold_cycles = 300;
         for (int n = 0; n < 78; n++) send_atoms(next_item());
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (120) @(negedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/dau_pkg.sv
rtl/dau_bond.sv
rtl/dau_cross.sv
rtl/dau_isqrt.sv
rtl/dau_dot.sv
rtl/dau_cordic.sv
rtl/dihedral_angle_unit.sv
rtl/dau_checker.sv
tb/sv/dihedral_checker.sv
tb/sv/testbench.sv
